// ===== hdl/btfla_pkg.sv =====
// ----------------------------------------------------------------------------
// btfla_pkg
// Types and constants shared by the boundary-tag free-list allocator.
// ----------------------------------------------------------------------------
package btfla_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_NOFIT = 1'b1;

  localparam logic [63:0] SPLIT_MIN = 64'd40;
  localparam logic [63:0] TAG_USED  = 64'd1;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_WALK_CHK,
    S_WALK_HDR,
    S_WALK_NXT,
    S_AL_SPLIT,
    S_AL_REST,
    S_AL_PUSH,
    S_FR_CHK,
    S_FR_HDR,
    S_FR_NXT,
    S_FR_NHDR,
    S_FR_MERGE_N,
    S_FR_PREV,
    S_FR_PFTR,
    S_FR_MERGE_P,
    S_FR_PUSH,
    S_UL_RDP,
    S_UL_RDN,
    S_UL_PREV,
    S_UL_NEXT,
    S_ST_HDR,
    S_ST_FTR,
    S_PU_NEXT,
    S_PU_PREV,
    S_PU_HEAD,
    S_RESULT
  } state_t;

endpackage

// ===== hdl/boundary_tag_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// boundary_tag_free_list_allocator
// First-fit heap allocator with boundary tags and an explicit LIFO free list.
//
// One request enters on the input channel (opcode, request_size,
// payload_address) and one result leaves on the output channel (status,
// granted_address). Each channel moves a transfer when valid is high and
// stall is low. The block works on one request at a time; all heap state
// lives in one single-port memory, and each step makes at most one memory
// access. An allocate walks the free list and takes the first block that
// fits, or reports no fit when none does. A free of a null or stray pointer
// goes straight to its result; otherwise it merges with free neighbours.
// The block returns to idle after each result.
// The next request is taken while a finished result still waits in the
// output register; a stalled output only holds the block in its final step.
// After reset the block writes the tags and links of the initial free block
// with the input stalled. heap_base resets to 0. Write it through cfg_we
// and cfg_wdata while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module boundary_tag_free_list_allocator
  import btfla_pkg::*;
#(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [47:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [15:0] request_size,
  input  logic [47:0] payload_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [47:0] granted_address
);

  localparam int AW = $clog2(HEAP_BYTES / 8);
  localparam logic [63:0] NIL = 64'(HEAP_BYTES);
  localparam logic [AW:0] STEPS_MAX = (AW + 1)'(HEAP_BYTES / 8);

  state_t      state, state_next;
  state_t      ret, ret_next;
  logic [63:0] cur, cur_next;
  logic [63:0] sz, sz_next;
  logic [63:0] hold, hold_next;
  logic [63:0] arg, arg_next;
  logic [63:0] asz, asz_next;
  logic        aused, aused_next;
  logic [63:0] lp, lp_next;
  logic [63:0] ln, ln_next;
  logic [63:0] head, head_next;
  logic [17:0] need, need_next;
  logic [AW:0] steps, steps_next;
  logic [1:0]  init_cnt, init_cnt_next;
  logic [47:0] addr_q, addr_q_next;
  logic        res_fail, res_fail_next;
  logic [47:0] res_addr, res_addr_next;
  logic [47:0] heap_base;

  logic        mem_we;
  logic [63:0] mem_off;
  logic [63:0] mem_wdata;
  logic [63:0] mem_rdata;

  logic [16:0] size17;
  logic [16:0] total17;
  logic [17:0] need_in;
  logic [47:0] blk48;
  logic [63:0] tag;
  logic [63:0] rd_size;

  btfla_ram #(.ADDR_W(AW)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_off[AW+2:3]),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_comb begin
    size17  = (request_size == 16'd0) ? 17'd1 : {1'b0, request_size};
    total17 = (size17 + 17'd23) & ~17'hF;
    need_in = (total17 < 17'd40) ? 18'd48 : ({1'b0, total17} + 18'd8);
    blk48   = addr_q - heap_base - 48'd8;
    tag     = (asz & ~TAG_USED) | {63'd0, aused};
    rd_size = mem_rdata & ~TAG_USED;
  end

  always_comb begin
    state_next    = state;
    ret_next      = ret;
    cur_next      = cur;
    sz_next       = sz;
    hold_next     = hold;
    arg_next      = arg;
    asz_next      = asz;
    aused_next    = aused;
    lp_next       = lp;
    ln_next       = ln;
    head_next     = head;
    need_next     = need;
    steps_next    = steps;
    init_cnt_next = init_cnt;
    addr_q_next   = addr_q;
    res_fail_next = res_fail;
    res_addr_next = res_addr;
    mem_we        = 1'b0;
    mem_off       = cur;
    mem_wdata     = tag;
    in_stall      = 1'b1;

    unique case (state)
      S_INIT: begin
        mem_we = 1'b1;
        unique case (init_cnt)
          2'd0: begin mem_off = 64'd0;      mem_wdata = NIL; end
          2'd1: begin mem_off = NIL - 64'd8; mem_wdata = NIL; end
          2'd2: begin mem_off = 64'd8;      mem_wdata = NIL; end
          default: begin mem_off = 64'd16;  mem_wdata = NIL; end
        endcase
        init_cnt_next = init_cnt + 2'd1;
        if (init_cnt == 2'd3) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          addr_q_next = payload_address;
          need_next   = need_in;
          cur_next    = head;
          steps_next  = '0;
          state_next  = (opcode == OP_ALLOC) ? S_WALK_CHK : S_FR_CHK;
        end
      end
      S_WALK_CHK: begin
        if (cur == NIL || steps == STEPS_MAX) begin
          res_fail_next = STATUS_NOFIT;
          res_addr_next = '0;
          state_next    = S_RESULT;
        end else begin
          mem_off    = cur;
          state_next = S_WALK_HDR;
        end
      end
      S_WALK_HDR: begin
        sz_next = rd_size;
        if (rd_size >= 64'(need)) begin
          arg_next   = cur;
          ret_next   = S_AL_SPLIT;
          state_next = S_UL_RDP;
        end else begin
          mem_off    = cur + 64'd16;
          state_next = S_WALK_NXT;
        end
      end
      S_WALK_NXT: begin
        cur_next   = mem_rdata;
        steps_next = steps + 1'b1;
        state_next = S_WALK_CHK;
      end
      S_AL_SPLIT: begin
        res_fail_next = STATUS_DONE;
        res_addr_next = heap_base + cur[47:0] + 48'd8;
        arg_next      = cur;
        aused_next    = 1'b1;
        state_next    = S_ST_HDR;
        if (sz - 64'(need) >= SPLIT_MIN) begin
          asz_next = 64'(need);
          ret_next = S_AL_REST;
        end else begin
          asz_next = sz;
          ret_next = S_RESULT;
        end
      end
      S_AL_REST: begin
        arg_next   = cur + 64'(need);
        asz_next   = sz - 64'(need);
        aused_next = 1'b0;
        ret_next   = S_AL_PUSH;
        state_next = S_ST_HDR;
      end
      S_AL_PUSH: begin
        arg_next   = cur + 64'(need);
        ret_next   = S_RESULT;
        state_next = S_PU_NEXT;
      end
      S_FR_CHK: begin
        res_fail_next = STATUS_DONE;
        res_addr_next = '0;
        if (addr_q == 48'd0 || blk48[2:0] != 3'd0 || 64'(blk48) > NIL - 64'd8) begin
          state_next = S_RESULT;
        end else begin
          cur_next   = 64'(blk48);
          mem_off    = 64'(blk48);
          state_next = S_FR_HDR;
        end
      end
      S_FR_HDR: begin
        sz_next    = rd_size;
        arg_next   = cur;
        asz_next   = rd_size;
        aused_next = 1'b0;
        ret_next   = S_FR_NXT;
        state_next = S_ST_HDR;
      end
      S_FR_NXT: begin
        if (cur + sz < NIL) begin
          mem_off    = cur + sz;
          state_next = S_FR_NHDR;
        end else begin
          state_next = S_FR_PREV;
        end
      end
      S_FR_NHDR: begin
        hold_next = mem_rdata;
        if (!mem_rdata[0]) begin
          arg_next   = cur + sz;
          ret_next   = S_FR_MERGE_N;
          state_next = S_UL_RDP;
        end else begin
          state_next = S_FR_PREV;
        end
      end
      S_FR_MERGE_N: begin
        sz_next    = sz + (hold & ~TAG_USED);
        arg_next   = cur;
        asz_next   = sz + (hold & ~TAG_USED);
        aused_next = 1'b0;
        ret_next   = S_FR_PREV;
        state_next = S_ST_HDR;
      end
      S_FR_PREV: begin
        if (cur != 64'd0) begin
          mem_off    = cur - 64'd8;
          state_next = S_FR_PFTR;
        end else begin
          state_next = S_FR_PUSH;
        end
      end
      S_FR_PFTR: begin
        hold_next = mem_rdata;
        if (!mem_rdata[0]) begin
          arg_next   = cur - rd_size;
          ret_next   = S_FR_MERGE_P;
          state_next = S_UL_RDP;
        end else begin
          state_next = S_FR_PUSH;
        end
      end
      S_FR_MERGE_P: begin
        sz_next    = sz + (hold & ~TAG_USED);
        cur_next   = arg;
        asz_next   = sz + (hold & ~TAG_USED);
        aused_next = 1'b0;
        ret_next   = S_FR_PUSH;
        state_next = S_ST_HDR;
      end
      S_FR_PUSH: begin
        arg_next   = cur;
        ret_next   = S_RESULT;
        state_next = S_PU_NEXT;
      end
      S_UL_RDP: begin
        mem_off    = arg + 64'd8;
        state_next = S_UL_RDN;
      end
      S_UL_RDN: begin
        lp_next    = mem_rdata;
        mem_off    = arg + 64'd16;
        state_next = S_UL_PREV;
      end
      S_UL_PREV: begin
        ln_next = mem_rdata;
        if (lp == NIL) begin
          head_next = mem_rdata;
        end else begin
          mem_we    = 1'b1;
          mem_off   = lp + 64'd16;
          mem_wdata = mem_rdata;
        end
        state_next = S_UL_NEXT;
      end
      S_UL_NEXT: begin
        if (ln != NIL) begin
          mem_we    = 1'b1;
          mem_off   = ln + 64'd8;
          mem_wdata = lp;
        end
        state_next = ret;
      end
      S_ST_HDR: begin
        mem_we     = 1'b1;
        mem_off    = arg;
        mem_wdata  = tag;
        state_next = S_ST_FTR;
      end
      S_ST_FTR: begin
        mem_we     = 1'b1;
        mem_off    = arg + asz - 64'd8;
        mem_wdata  = tag;
        state_next = ret;
      end
      S_PU_NEXT: begin
        mem_we     = 1'b1;
        mem_off    = arg + 64'd16;
        mem_wdata  = head;
        state_next = S_PU_PREV;
      end
      S_PU_PREV: begin
        mem_we     = 1'b1;
        mem_off    = arg + 64'd8;
        mem_wdata  = NIL;
        state_next = S_PU_HEAD;
      end
      S_PU_HEAD: begin
        if (head != NIL) begin
          mem_we    = 1'b1;
          mem_off   = head + 64'd8;
          mem_wdata = arg;
        end
        head_next  = arg;
        state_next = ret;
      end
      S_RESULT: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      ret       <= S_IDLE;
      head      <= 64'd0;
      init_cnt  <= 2'd0;
      steps     <= '0;
      heap_base <= 48'd0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      head     <= head_next;
      init_cnt <= init_cnt_next;
      steps    <= steps_next;
      if (cfg_we) begin
        heap_base <= cfg_wdata;
      end
      if (state == S_RESULT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    sz       <= sz_next;
    hold     <= hold_next;
    arg      <= arg_next;
    asz      <= asz_next;
    aused    <= aused_next;
    lp       <= lp_next;
    ln       <= ln_next;
    need     <= need_next;
    addr_q   <= addr_q_next;
    res_fail <= res_fail_next;
    res_addr <= res_addr_next;
    if (state == S_RESULT && (!out_valid || !out_stall)) begin
      status          <= res_fail;
      granted_address <= res_addr;
    end
  end

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a request is in progress");

  a_result_from_final_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RESULT)
    else $error("result raised outside the final step");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    steps <= STEPS_MAX)
    else $error("free-list walk exceeded its bound");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_RESULT) |-> !mem_we)
    else $error("heap written while no request is in progress");

endmodule

// ===== hdl/btfla_ram.sv =====
// ----------------------------------------------------------------------------
// btfla_ram
// Single-port heap word memory with registered read data (read-first).
// ----------------------------------------------------------------------------
module btfla_ram #(
  parameter int ADDR_W = 13
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [63:0]       wdata,
  output logic [63:0]       rdata
);

  logic [63:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
